/* hdl/tfc_pkg.sv */
package tfc_pkg;

    localparam int FLOWS      = 32;
    localparam int CNT_W      = $clog2(FLOWS + 1);
    localparam int IDX_W      = $clog2(FLOWS);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

    localparam logic [1:0] OP_PKT   = 2'd0;
    localparam logic [1:0] OP_OTHER = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [1:0] RSN_ACTIVE   = 2'd0;
    localparam logic [1:0] RSN_INACTIVE = 2'd1;
    localparam logic [1:0] RSN_FLUSH    = 2'd2;
    localparam logic [1:0] RSN_EVICT    = 2'd3;

    localparam logic [1:0] CFG_ACTIVE   = 2'd0;
    localparam logic [1:0] CFG_INACTIVE = 2'd1;
    localparam logic [1:0] CFG_BASE     = 2'd2;

    typedef enum logic [1:0] {
        K_PKT   = 2'd0,
        K_AGE   = 2'd1,
        K_FLUSH = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] time_ms;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  tcp_flags;
        logic [15:0] ip_bytes;
    } t_item;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] packets;
        logic [31:0] bytes;
        logic [7:0]  flags;
        logic [31:0] first_time;
        logic [31:0] last_time;
    } t_entry;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] packets;
        logic [31:0] bytes;
        logic [7:0]  flags;
        logic [31:0] first_up;
        logic [31:0] last_up;
        logic [1:0]  reason;
        logic        last;
    } t_rec;

    function automatic t_rec make_rec(t_entry e, logic [1:0] reason, logic [31:0] base);
        t_rec r;
        r.src_addr = e.src_addr;
        r.dst_addr = e.dst_addr;
        r.sport    = e.sport;
        r.dport    = e.dport;
        r.packets  = e.packets;
        r.bytes    = e.bytes;
        r.flags    = e.flags;
        r.first_up = e.first_time - base;
        r.last_up  = e.last_time - base;
        r.reason   = reason;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

/* hdl/tfc_ram.sv */
module tfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tfc_front.sv */
module tfc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [1:0]     i_opcode,
    input  logic [31:0]    i_time_ms,
    input  logic [31:0]    i_src_addr,
    input  logic [31:0]    i_dst_addr,
    input  logic [15:0]    i_sport,
    input  logic [15:0]    i_dport,
    input  logic [7:0]     i_tcp_flags,
    input  logic [15:0]    i_ip_bytes,
    output logic           o_item_valid,
    output tfc_pkg::t_item o_item,
    input  logic           i_item_pop
);
    import tfc_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       accept;
    t_item      item;

    assign o_stall      = (r_cnt == 2'd2);
    assign accept       = i_valid && !o_stall;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_comb begin
        item.time_ms   = i_time_ms;
        item.src_addr  = i_src_addr;
        item.dst_addr  = i_dst_addr;
        item.sport     = i_sport;
        item.dport     = i_dport;
        item.tcp_flags = i_tcp_flags;
        item.ip_bytes  = i_ip_bytes;
        // The unused opcode behaves as a non-TCP packet.
        unique case (i_opcode)
            OP_PKT:   item.kind = K_PKT;
            OP_FLUSH: item.kind = K_FLUSH;
            default:  item.kind = K_AGE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_wp <= !r_wp;
            end
            if (i_item_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(accept) - 2'(i_item_pop);
        end
    end

endmodule

/* hdl/tfc_outq.sv */
module tfc_outq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  tfc_pkg::t_rec                  i_rec,
    output logic [tfc_pkg::OUTQ_CNT_W-1:0] o_free,
    output logic                           o_valid,
    input  logic                           i_stall,
    output tfc_pkg::t_rec                  o_rec
);
    import tfc_pkg::*;

    t_rec                  r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wp;
    logic [OUTQ_PTR_W-1:0] r_rp;
    logic [OUTQ_CNT_W-1:0] r_cnt;
    logic                  pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign o_rec   = r_mem[r_rp];
    assign o_free  = OUTQ_CNT_W'(OUTQ_DEPTH) - r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + OUTQ_PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + OUTQ_PTR_W'(1);
            end
            r_cnt <= r_cnt + OUTQ_CNT_W'(i_push) - OUTQ_CNT_W'(pop);
        end
    end

endmodule

/* hdl/tfc_engine.sv */
module tfc_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [31:0]                    i_active_to,
    input  logic [31:0]                    i_inactive_to,
    input  logic [31:0]                    i_base,
    input  logic                           i_item_valid,
    input  tfc_pkg::t_item                 i_item,
    output logic                           o_item_pop,
    input  logic [tfc_pkg::OUTQ_CNT_W-1:0] i_free,
    output logic                           o_push,
    output tfc_pkg::t_rec                  o_rec
);
    import tfc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_APPEND,
        S_DONE
    } t_state;

    t_state           r_state;
    t_item            r_item;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_lim;
    logic [CNT_W-1:0] r_w;
    logic             r_hit;
    logic             r_shift;
    logic [IDX_W-1:0] r_app;
    logic             r_p_valid;
    logic [IDX_W-1:0] r_p_idx;
    logic             r_pend_valid;
    t_rec             r_pend;

    t_entry           rd_ent;
    t_entry           wr_ent;
    t_entry           upd_ent;
    t_entry           new_ent;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             issue;
    logic             emit;
    logic [1:0]       reason;
    logic             is_act;
    logic             is_ina;
    logic             match;
    logic             run_end;

    tfc_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(FLOWS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wr_ent),
        .i_raddr(r_i[IDX_W-1:0]),
        .o_rdata(rd_ent)
    );

    // A read is issued only with room for the record it may yield plus one in flight.
    assign issue   = (r_state == S_RUN) && (r_i < r_lim) && (i_free >= OUTQ_CNT_W'(2));
    assign run_end = (r_state == S_RUN) && (r_i == r_lim) && !r_p_valid;
    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;

    always_comb begin
        is_act = (r_item.time_ms - rd_ent.first_time) >= i_active_to;
        is_ina = (r_item.time_ms - rd_ent.last_time) >= i_inactive_to;
        match  = (r_item.kind == K_PKT) && (rd_ent.src_addr == r_item.src_addr)
               && (rd_ent.dst_addr == r_item.dst_addr)
               && (rd_ent.sport == r_item.sport)
               && (rd_ent.dport == r_item.dport);

        upd_ent = rd_ent;
        if (match) begin
            upd_ent.packets   = rd_ent.packets + 32'd1;
            upd_ent.bytes     = rd_ent.bytes + {16'd0, r_item.ip_bytes};
            upd_ent.flags     = rd_ent.flags | r_item.tcp_flags;
            upd_ent.last_time = r_item.time_ms;
        end

        new_ent.src_addr   = r_item.src_addr;
        new_ent.dst_addr   = r_item.dst_addr;
        new_ent.sport      = r_item.sport;
        new_ent.dport      = r_item.dport;
        new_ent.packets    = 32'd1;
        new_ent.bytes      = {16'd0, r_item.ip_bytes};
        new_ent.flags      = r_item.tcp_flags;
        new_ent.first_time = r_item.time_ms;
        new_ent.last_time  = r_item.time_ms;

        if (r_shift) begin
            emit   = (r_p_idx == '0);
            reason = RSN_EVICT;
        end else begin
            emit = (r_item.kind == K_FLUSH) || is_act || is_ina;
            priority if (r_item.kind == K_FLUSH) begin
                reason = RSN_FLUSH;
            end else if (is_act) begin
                reason = RSN_ACTIVE;
            end else begin
                reason = RSN_INACTIVE;
            end
        end

        if (r_state == S_APPEND) begin
            we     = 1'b1;
            waddr  = r_app;
            wr_ent = new_ent;
        end else begin
            we     = r_p_valid && !emit;
            waddr  = r_shift ? (r_p_idx - IDX_W'(1)) : r_w[IDX_W-1:0];
            wr_ent = r_shift ? rd_ent : upd_ent;
        end

        // The held record goes out once the next one, or the end of the item, is known.
        o_rec = r_pend;
        if (r_state == S_DONE) begin
            o_rec.last = 1'b1;
            o_push     = r_pend_valid && (i_free != '0);
        end else begin
            o_push = r_p_valid && emit && r_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_item <= i_item;
        end
        if (r_p_valid && emit) begin
            r_pend <= make_rec(rd_ent, reason, i_base);
        end
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_i          <= '0;
            r_lim        <= '0;
            r_w          <= '0;
            r_hit        <= 1'b0;
            r_shift      <= 1'b0;
            r_app        <= '0;
            r_p_valid    <= 1'b0;
            r_p_idx      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_p_valid <= issue;
            if (issue) begin
                r_p_idx <= r_i[IDX_W-1:0];
                r_i     <= r_i + CNT_W'(1);
            end
            if (r_p_valid) begin
                if (emit) begin
                    r_pend_valid <= 1'b1;
                end else if (!r_shift) begin
                    r_w <= r_w + CNT_W'(1);
                    if (match) begin
                        r_hit <= 1'b1;
                    end
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_i     <= '0;
                        r_lim   <= r_cnt;
                        r_w     <= '0;
                        r_hit   <= 1'b0;
                        r_shift <= 1'b0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (run_end) begin
                        if (r_shift) begin
                            r_app   <= IDX_W'(FLOWS - 1);
                            r_state <= S_APPEND;
                        end else begin
                            r_cnt <= r_w;
                            if (r_item.kind == K_PKT && !r_hit) begin
                                if (r_w == CNT_W'(FLOWS)) begin
                                    // Full table: evict the oldest and close up by one.
                                    r_shift <= 1'b1;
                                    r_i     <= '0;
                                    r_lim   <= CNT_W'(FLOWS);
                                end else begin
                                    r_app   <= r_w[IDX_W-1:0];
                                    r_state <= S_APPEND;
                                end
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_APPEND: begin
                    r_cnt   <= {1'b0, r_app} + CNT_W'(1);
                    r_shift <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (i_free != '0) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/tcp_flow_cache_with_aging.sv */
// TCP flow cache with active and inactive aging.
// Input channel: i_valid / o_stall with one packet, aging tick or flush per item.
// Output channel: o_valid / i_stall with one exported flow record per transfer; o_rec_last
// marks the final record caused by an input, and an input that exports nothing
// gives no record at all.
// Configuration: i_cfg_we writes register i_cfg_idx (0 active timeout, 1 inactive
// timeout, 2 uptime base) with i_cfg_data; index 3 is ignored.
// Each item walks every stored flow in the flow memory, one entry per cycle while the
// output queue has room. A new flow that meets a full table costs a second pass over
// the table to close it up.
// A two-item queue in front lets the next item be taken while one is worked on.
// Records wait in a four-deep output queue; when the receiver stalls, the walk
// pauses once that queue is nearly full, and input stalls once the front queue fills.
// A record is passed on once the next record of its item, or the end of the item, is
// known.
// Reset empties the table and restores timeouts of 60000 ms and a base of zero.
module tcp_flow_cache_with_aging (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_time_ms,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_sport,
    input  logic [15:0] i_dport,
    input  logic [7:0]  i_tcp_flags,
    input  logic [15:0] i_ip_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_rec_src_addr,
    output logic [31:0] o_rec_dst_addr,
    output logic [15:0] o_rec_sport,
    output logic [15:0] o_rec_dport,
    output logic [31:0] o_rec_packets,
    output logic [31:0] o_rec_bytes,
    output logic [7:0]  o_rec_flags,
    output logic [31:0] o_rec_first_uptime,
    output logic [31:0] o_rec_last_uptime,
    output logic [1:0]  o_rec_reason,
    output logic        o_rec_last
);
    import tfc_pkg::*;

    logic [31:0]           r_active_to;
    logic [31:0]           r_inactive_to;
    logic [31:0]           r_base;
    logic                  item_valid;
    t_item                 item;
    logic                  item_pop;
    logic [OUTQ_CNT_W-1:0] free;
    logic                  push;
    t_rec                  push_rec;
    t_rec                  rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_to   <= 32'd60000;
            r_inactive_to <= 32'd60000;
            r_base        <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACTIVE:   r_active_to   <= i_cfg_data;
                CFG_INACTIVE: r_inactive_to <= i_cfg_data;
                CFG_BASE:     r_base        <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    tfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_time_ms   (i_time_ms),
        .i_src_addr  (i_src_addr),
        .i_dst_addr  (i_dst_addr),
        .i_sport     (i_sport),
        .i_dport     (i_dport),
        .i_tcp_flags (i_tcp_flags),
        .i_ip_bytes  (i_ip_bytes),
        .o_item_valid(item_valid),
        .o_item      (item),
        .i_item_pop  (item_pop)
    );

    tfc_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_active_to  (r_active_to),
        .i_inactive_to(r_inactive_to),
        .i_base       (r_base),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .i_free       (free),
        .o_push       (push),
        .o_rec        (push_rec)
    );

    tfc_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_rec  (push_rec),
        .o_free (free),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rec  (rec)
    );

    assign o_rec_src_addr     = rec.src_addr;
    assign o_rec_dst_addr     = rec.dst_addr;
    assign o_rec_sport        = rec.sport;
    assign o_rec_dport        = rec.dport;
    assign o_rec_packets      = rec.packets;
    assign o_rec_bytes        = rec.bytes;
    assign o_rec_flags        = rec.flags;
    assign o_rec_first_uptime = rec.first_up;
    assign o_rec_last_uptime  = rec.last_up;
    assign o_rec_reason       = rec.reason;
    assign o_rec_last         = rec.last;

endmodule
